// ===== src/bma_pkg.sv =====
`timescale 1ns / 1ps

package bma_pkg;

  localparam int NumLevelsDef  = 10;
  localparam int StackDepthDef = 64;
  localparam int NumBlocksDef  = 16;

  localparam int BlkW   = 4;
  localparam int OffW   = 40;
  localparam int SizeW  = 41;
  localparam int EntryW = BlkW + OffW;
  localparam int BslW   = 6;

  localparam logic [BslW-1:0] BslMax   = 6'd40;
  localparam logic [BslW-1:0] BslReset = 6'd24;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARENT   = 2'd1,
    ST_NO_BLOCK = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_LOG,
    S_SRCH,
    S_CHK,
    S_POP,
    S_POPW,
    S_SPLIT,
    S_FRD,
    S_FCMP,
    S_FMV,
    S_DONE
  } state_e;

endpackage

// ===== src/buddy_memory_allocator.sv =====
`timescale 1ns / 1ps

// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | op, req_size, req_align, chunk_block/offset/size
// out     | out | out_valid_o / out_stall_i | status, granted_block/offset/size
// cfg     | in  | cfg_valid_i / cfg_ready_o | block_size_log2
//
// one item at a time; size rounding takes one from the size, then halves it once per bit,
// capped at the block size log2.
// allocate searches the levels for a non-empty stack, checks room, then pops and splits.
// free scans each level's stack through the memory read port, comparing each entry with
// the buddy, and merges up level by level while the buddy is found.
// reset clears counts and the block map; stack memory is not cleared.
// a finished result waits in the output register while the next item is taken.

module buddy_memory_allocator #(
  parameter int NUM_LEVELS  = bma_pkg::NumLevelsDef,
  parameter int STACK_DEPTH = bma_pkg::StackDepthDef,
  parameter int NUM_BLOCKS  = bma_pkg::NumBlocksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bma_pkg::BslW-1:0]     cfg_block_size_log2_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [bma_pkg::SizeW-1:0]    req_size_i,
  input  logic [bma_pkg::SizeW-1:0]    req_align_i,
  input  logic [bma_pkg::BlkW-1:0]     chunk_block_i,
  input  logic [bma_pkg::OffW-1:0]     chunk_offset_i,
  input  logic [bma_pkg::SizeW-1:0]    chunk_size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [bma_pkg::BlkW-1:0]     granted_block_o,
  output logic [bma_pkg::OffW-1:0]     granted_offset_o,
  output logic [bma_pkg::SizeW-1:0]    granted_size_o
);
  import bma_pkg::*;

  localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int LCW   = $clog2(NUM_LEVELS + 1);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int DW    = $clog2(STACK_DEPTH);
  localparam int Words = NUM_LEVELS * STACK_DEPTH;
  localparam int AW    = $clog2(Words);
  localparam int Pool  = (NUM_BLOCKS < 16) ? NUM_BLOCKS : 16;
  localparam int MapW  = 1 << BlkW;

  localparam logic [CW-1:0]  DepthC  = CW'(STACK_DEPTH);
  localparam logic [BslW-1:0] LevelsC = BslW'(NUM_LEVELS);

  state_e               state_q, state_d;
  logic [BslW-1:0]      bsl_q;
  logic                 op_q, op_d;
  logic [SizeW-1:0]     sz_q, sz_d;
  logic [BslW-1:0]      s_q, s_d;
  logic [LCW-1:0]       lvl_q, lvl_d;
  logic [LCW-1:0]       j_q, j_d;
  logic [LCW-1:0]       src_q, src_d;
  logic                 pool_q, pool_d;
  logic [BlkW-1:0]      blk_q, blk_d;
  logic [OffW-1:0]      off_q, off_d;
  logic [SizeW-1:0]     csz_q, csz_d;
  logic [CW-1:0]        k_q, k_d;
  logic [1:0]           rst_q, rst_d;
  logic [BlkW-1:0]      rblk_q, rblk_d;
  logic [OffW-1:0]      roff_q, roff_d;
  logic [SizeW-1:0]     rsz_q, rsz_d;
  logic [CW-1:0]        cnt_q [NUM_LEVELS];
  logic [MapW-1:0]      used_q, used_d;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q;
  logic [BlkW-1:0]      out_blk_q;
  logic [OffW-1:0]      out_off_q;
  logic [SizeW-1:0]     out_sz_q;
  logic                 out_load;

  logic [EntryW-1:0]    mem_q [Words];
  logic [EntryW-1:0]    mem_rdata_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [EntryW-1:0]    mem_wdata;

  logic                 cnt_we;
  logic [LCW-1:0]       cnt_idx;
  logic [CW-1:0]        cnt_wval;

  logic [BslW-1:0]      bsl;
  logic [BslW-1:0]      top;
  logic                 free_found;
  logic [BlkW-1:0]      free_blk;
  logic [CW-1:0]        cnt_lvl, cnt_i, cnt_j, cnt_src;

  function automatic logic [AW-1:0] maddr(input logic [LCW-1:0] l, input logic [CW-1:0] i);
    logic [AW-1:0] a;
    a = AW'(l) * AW'(STACK_DEPTH) + AW'(i[DW-1:0]);
    return a;
  endfunction

  assign bsl = (bsl_q > BslMax) ? BslMax : bsl_q;

  assign cnt_lvl = cnt_q[lvl_q[LW-1:0]];
  assign cnt_i   = cnt_q[j_q[LW-1:0]];
  assign cnt_j   = cnt_i;
  assign cnt_src = cnt_q[src_q[LW-1:0]];

  // lowest unused block of the pool
  always_comb begin
    free_found = 1'b0;
    free_blk   = '0;
    for (int b = MapW - 1; b >= 0; b--) begin
      if (b < Pool && !used_q[b]) begin
        free_found = 1'b1;
        free_blk   = BlkW'(b);
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    sz_d     = sz_q;
    s_d      = s_q;
    lvl_d    = lvl_q;
    j_d      = j_q;
    src_d    = src_q;
    pool_d   = pool_q;
    blk_d    = blk_q;
    off_d    = off_q;
    csz_d    = csz_q;
    k_d      = k_q;
    rst_d    = rst_q;
    rblk_d   = rblk_q;
    roff_d   = roff_q;
    rsz_d    = rsz_q;
    used_d   = used_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    cnt_we    = 1'b0;
    cnt_idx   = '0;
    cnt_wval  = '0;
    top       = bsl - s_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d  = op_i;
          blk_d = chunk_block_i;
          off_d = chunk_offset_i;
          if (op_i) begin
            sz_d = chunk_size_i;
          end else begin
            sz_d = (req_size_i > req_align_i) ? req_size_i : req_align_i;
          end
          rst_d   = ST_OK;
          rblk_d  = '0;
          roff_d  = '0;
          rsz_d   = '0;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        sz_d    = (sz_q <= SizeW'(1)) ? '0 : sz_q - SizeW'(1);
        s_d     = '0;
        state_d = S_LOG;
      end
      S_LOG: begin
        if (sz_q != '0 && s_q < bsl) begin
          sz_d = sz_q >> 1;
          s_d  = s_q + BslW'(1);
        end else if (s_q >= bsl) begin
          rst_d   = ST_PARENT;
          state_d = S_DONE;
        end else begin
          if (top > LevelsC) begin
            top = LevelsC;
          end
          lvl_d = LCW'(top - BslW'(1));
          if (op_q) begin
            csz_d   = SizeW'(1) << (bsl - BslW'(1) - BslW'(lvl_d));
            k_d     = '0;
            state_d = S_FRD;
          end else begin
            j_d     = LCW'(top - BslW'(1));
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (cnt_i != '0) begin
          src_d   = j_q;
          pool_d  = 1'b0;
          j_d     = j_q + LCW'(1);
          state_d = S_CHK;
        end else if (j_q == '0) begin
          if (!free_found) begin
            rst_d   = ST_NO_BLOCK;
            state_d = S_DONE;
          end else begin
            blk_d   = free_blk;
            pool_d  = 1'b1;
            j_d     = '0;
            state_d = S_CHK;
          end
        end else begin
          j_d = j_q - LCW'(1);
        end
      end
      S_CHK: begin
        if (j_q > lvl_q) begin
          state_d = S_POP;
        end else if (cnt_j == DepthC) begin
          rst_d   = ST_OVERFLOW;
          state_d = S_DONE;
        end else begin
          j_d = j_q + LCW'(1);
        end
      end
      S_POP: begin
        if (pool_q) begin
          used_d[blk_q] = 1'b1;
          off_d   = '0;
          csz_d   = SizeW'(1) << bsl;
          j_d     = '0;
          state_d = S_SPLIT;
        end else begin
          cnt_we    = 1'b1;
          cnt_idx   = src_q;
          cnt_wval  = cnt_src - CW'(1);
          mem_re    = 1'b1;
          mem_raddr = maddr(src_q, cnt_src - CW'(1));
          j_d       = src_q + LCW'(1);
          state_d   = S_POPW;
        end
      end
      S_POPW: begin
        blk_d   = mem_rdata_q[EntryW-1:OffW];
        off_d   = mem_rdata_q[OffW-1:0];
        csz_d   = SizeW'(1) << (bsl - BslW'(1) - BslW'(src_q));
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (j_q > lvl_q) begin
          rst_d   = ST_OK;
          rblk_d  = blk_q;
          roff_d  = off_q;
          rsz_d   = csz_q;
          state_d = S_DONE;
        end else begin
          // lower half goes on the stack, upper half is kept
          mem_we    = 1'b1;
          mem_waddr = maddr(j_q, cnt_j);
          mem_wdata = {blk_q, off_q};
          cnt_we    = 1'b1;
          cnt_idx   = j_q;
          cnt_wval  = cnt_j + CW'(1);
          csz_d     = csz_q >> 1;
          off_d     = off_q + csz_d[OffW-1:0];
          j_d       = j_q + LCW'(1);
        end
      end
      S_FRD: begin
        if (k_q == cnt_lvl) begin
          if (cnt_lvl == DepthC) begin
            rst_d = ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = maddr(lvl_q, cnt_lvl);
            mem_wdata = {blk_q, off_q};
            cnt_we    = 1'b1;
            cnt_idx   = lvl_q;
            cnt_wval  = cnt_lvl + CW'(1);
          end
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = maddr(lvl_q, k_q);
          state_d   = S_FCMP;
        end
      end
      S_FCMP: begin
        if (mem_rdata_q == {blk_q, off_q ^ csz_q[OffW-1:0]}) begin
          // fetch the top entry to fill the hole left by the buddy
          mem_re    = 1'b1;
          mem_raddr = maddr(lvl_q, cnt_lvl - CW'(1));
          state_d   = S_FMV;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = S_FRD;
        end
      end
      S_FMV: begin
        mem_we    = 1'b1;
        mem_waddr = maddr(lvl_q, k_q);
        mem_wdata = mem_rdata_q;
        cnt_we    = 1'b1;
        cnt_idx   = lvl_q;
        cnt_wval  = cnt_lvl - CW'(1);
        off_d     = off_q & ~csz_q[OffW-1:0];
        csz_d     = csz_q << 1;
        if (lvl_q == '0) begin
          used_d[blk_q] = 1'b0;
          state_d       = S_DONE;
        end else begin
          lvl_d   = lvl_q - LCW'(1);
          k_d     = '0;
          state_d = S_FRD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bsl_q       <= BslReset;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        bsl_q <= cfg_block_size_log2_i;
      end
      if (cnt_we) begin
        cnt_q[cnt_idx[LW-1:0]] <= cnt_wval;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sz_q   <= sz_d;
    s_q    <= s_d;
    lvl_q  <= lvl_d;
    j_q    <= j_d;
    src_q  <= src_d;
    pool_q <= pool_d;
    blk_q  <= blk_d;
    off_q  <= off_d;
    csz_q  <= csz_d;
    k_q    <= k_d;
    rst_q  <= rst_d;
    rblk_q <= rblk_d;
    roff_q <= roff_d;
    rsz_q  <= rsz_d;
    if (out_load) begin
      out_status_q <= rst_q;
      out_blk_q    <= rblk_q;
      out_off_q    <= roff_q;
      out_sz_q     <= rsz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign granted_block_o  = out_blk_q;
  assign granted_offset_o = out_off_q;
  assign granted_size_o   = out_sz_q;

endmodule
